/* rtl/sparse_coordinate_element_store_unit_assert.svh */
// Assertion macros for the checker file of the element store.
`ifndef SPARSE_COORDINATE_ELEMENT_STORE_UNIT_ASSERT_SVH
`define SPARSE_COORDINATE_ELEMENT_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCESU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("element store assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCESU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("element store assertion failed");

`endif

/* rtl/scesu_pkg.sv */
// Types and codes shared by the sparse coordinate element store.
package scesu_pkg;

  // Request kinds.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One request.
  typedef struct packed {
    logic               kind;
    logic [9:0]         row;
    logic [9:0]         col;
    logic signed [31:0] value;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic               status;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_RESP
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic cnt_inc;
    logic rd_en;
    logic cmp_en;
    logic commit;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic cnt_zero;
    logic cnt_last;
    logic cnt_end;
  } sts_t;

endpackage

/* rtl/scesu_dpath.sv */
// Datapath: slot memory, scan counter, match tracking and result register.
module scesu_dpath
  import scesu_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int INDEX_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_item_t out_data
);

  localparam int KEY_W  = 2 * INDEX_BITS;
  localparam int WORD_W = 1 + KEY_W + 32;
  localparam int AW     = $clog2(ENTRIES);
  localparam int CW     = $clog2(ENTRIES + 1);

  // Slot word: valid bit, key, value.
  logic [WORD_W-1:0] mem [ENTRIES];

  logic               kind_r;
  logic [KEY_W-1:0]   key_r;
  logic signed [31:0] value_r;

  logic [CW-1:0]      cnt_r;
  logic [WORD_W-1:0]  rd_data_r;
  logic [AW-1:0]      rd_idx_r;

  logic               hit_r;
  logic [AW-1:0]      hit_idx_r;
  logic signed [31:0] hit_val_r;
  logic               free_r;
  logic [AW-1:0]      free_idx_r;

  out_item_t          out_r;

  logic               rd_valid;
  logic [KEY_W-1:0]   rd_key;
  logic [31:0]        rd_val;
  logic [KEY_W-1:0]   in_key;
  logic               val_nz;
  logic               full;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [WORD_W-1:0]  wr_data;

  // Key from the incoming indices, each cut or widened to INDEX_BITS.
  assign in_key = {INDEX_BITS'(in_data.row), INDEX_BITS'(in_data.col)};

  assign rd_valid = rd_data_r[WORD_W-1];
  assign rd_key   = rd_data_r[WORD_W-2 -: KEY_W];
  assign rd_val   = rd_data_r[31:0];

  assign val_nz = (value_r != 32'sd0);
  assign full   = (kind_r == KIND_WRITE) && val_nz && !hit_r && !free_r;

  // Counter status.
  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.cnt_last = (cnt_r == CW'(ENTRIES - 1));
  assign sts.cnt_end  = (cnt_r == CW'(ENTRIES));

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_data.kind;
      key_r   <= in_key;
      value_r <= in_data.value;
    end
  end

  // Scan / clear counter; starts at slot 0 for the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.capture) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // Registered memory read.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[cnt_r[AW-1:0]];
      rd_idx_r  <= cnt_r[AW-1:0];
    end
  end

  // Match and lowest-free tracking over the scanned slots.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.cmp_en) begin
      if (rd_valid && (rd_key == key_r) && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
        hit_val_r <= rd_val;
      end
      if (!rd_valid && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
    end
  end

  // Write port: clearing pass, or the single update of a write request.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    wr_data = '0;
    priority if (cmd.clr_wr) begin
      wr_en = 1'b1;
    end else if (cmd.commit && (kind_r == KIND_WRITE)) begin
      priority if (hit_r) begin
        // update in place, or free the slot on a zero value
        wr_en   = 1'b1;
        wr_addr = hit_idx_r;
        wr_data = {val_nz, key_r, value_r};
      end else if (val_nz && free_r) begin
        wr_en   = 1'b1;
        wr_addr = free_idx_r;
        wr_data = {1'b1, key_r, value_r};
      end else begin
        wr_en = 1'b0;
      end
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.read_value <= ((kind_r == KIND_READ) && hit_r) ? hit_val_r : 32'sd0;
      out_r.found      <= hit_r;
      out_r.status     <= full ? STATUS_FULL : STATUS_OK;
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/scesu_ctrl.sv */
// Controller: clearing pass, slot scan sequencing and result handshake.
module scesu_ctrl
  import scesu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.cnt_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid)     state_nxt = ST_SCAN;
      ST_SCAN:   if (sts.cnt_end)  state_nxt = ST_COMMIT;
      ST_COMMIT:                   state_nxt = ST_RESP;
      ST_RESP:   if (out_free)     state_nxt = ST_IDLE;
      default:                     state_nxt = ST_CLEAR;
    endcase
  end

  // Commands.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_SCAN: begin
        // issue slot cnt, compare slot cnt-1
        cmd.rd_en   = !sts.cnt_end;
        cmd.cnt_inc = !sts.cnt_end;
        cmd.cmp_en  = !sts.cnt_zero;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      ST_RESP: begin
        cmd.load_out = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/sparse_coordinate_element_store_unit.sv */
// Top level of the sparse coordinate element store.
// Fully associative table of ENTRIES (row, col, value) slots held in one
// memory. Each request is taken in the idle state and then scans every
// slot through the memory read port, one slot a cycle, to find the
// matching key and the lowest free slot; a write then updates, frees or
// fills one slot. The next request is taken only after the scan, commit
// and result steps of the one before, and later while an earlier result
// is still stalled at the output. The result sits in an output register,
// so the next request can be taken while it waits. After reset a clearing
// pass marks every slot free; no request is taken during it.
module sparse_coordinate_element_store_unit
  import scesu_pkg::*;
#(
  parameter int ENTRIES    = 64,
  parameter int INDEX_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  cmd_t cmd;
  sts_t sts;

  scesu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  scesu_dpath #(
    .ENTRIES    (ENTRIES),
    .INDEX_BITS (INDEX_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

/* rtl/scesu_checker.sv */
// Port-level checker for the element store, bound to the top level.
`include "sparse_coordinate_element_store_unit_assert.svh"

module scesu_checker
  import scesu_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a present key is never reported as a dropped write
  `SCESU_ASSERT_NOW(a_found_not_full, out_valid, !(out_data.found && out_data.status))

  // a dropped write returns no value
  `SCESU_ASSERT_NOW(a_full_zero, out_valid && out_data.status, out_data.read_value == 32'sd0)

  // one request at a time: the cycle after a request is taken stalls
  `SCESU_ASSERT_NEXT(a_one_at_time, in_valid && !in_stall, in_stall)

  // a stalled result holds
  `SCESU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind sparse_coordinate_element_store_unit scesu_checker u_scesu_checker (.*);

/* verif/tb.sv */
// Self-checking testbench for the sparse coordinate element store.
module tb
  import scesu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = 64;
  localparam int KEY_IDX     = 10;
  localparam int POOL        = 72;   // more keys than slots, so the table fills
  localparam int MIXED_OPS   = 150;
  localparam int DRAIN_OPS   = 80;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    in_item_t req;
    bit       hold_for_drain;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  pending_t  pend[$];
  out_item_t expected_results[$];
  int        sent_count = 0;
  int        got_count = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 14;
  int        recv_idle_pct = 80;

  // Shadow copy of the table
  logic [2*KEY_IDX-1:0] slot_key [TABLE_SLOTS];
  logic signed [31:0]   slot_val [TABLE_SLOTS];
  bit                   slot_used [TABLE_SLOTS];

  // Tallies for the closing summary
  int n_reads = 0, n_hits = 0, n_writes = 0, n_deletes = 0, n_full = 0;

  // Key pool for the random part
  logic [9:0] pool_row [POOL];
  logic [9:0] pool_col [POOL];

  sparse_coordinate_element_store_unit #(
    .ENTRIES    (TABLE_SLOTS),
    .INDEX_BITS (KEY_IDX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Apply one request to the shadow table and return the result it should give
  function automatic out_item_t apply_to_table(in_item_t req);
    logic [2*KEY_IDX-1:0] key;
    int hit;
    int free_at;
    int i;
    out_item_t res;
    key = {req.row[KEY_IDX-1:0], req.col[KEY_IDX-1:0]};
    hit = -1;
    free_at = -1;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == key) hit = i;
      if (free_at < 0 && !slot_used[i]) free_at = i;
    end
    res.read_value = '0;
    res.found = (hit >= 0);
    res.status = STATUS_OK;
    if (hit >= 0) n_hits++;
    if (req.kind == KIND_READ) begin
      n_reads++;
      if (hit >= 0) res.read_value = slot_val[hit];
    end else if (req.value == 0) begin
      n_deletes++;
      if (hit >= 0) slot_used[hit] = 1'b0;
    end else if (hit >= 0) begin
      n_writes++;
      slot_val[hit] = req.value;
    end else begin
      n_writes++;
      if (free_at >= 0) begin
        // new key goes to the lowest free slot
        slot_key[free_at] = key;
        slot_val[free_at] = req.value;
        slot_used[free_at] = 1'b1;
      end else begin
        res.status = STATUS_FULL;
        n_full++;
      end
    end
    return res;
  endfunction

  function automatic logic signed [31:0] rand_nonzero();
    logic signed [31:0] v;
    case ($urandom_range(9))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2: v = -32'sd1;
      3: v = 32'sd1;
      default: v = $urandom;
    endcase
    if (v == 0) v = 32'sd1;
    return v;
  endfunction

  task automatic push_req(logic kind, logic [9:0] row, logic [9:0] col,
                          logic signed [31:0] value, bit hold);
    pending_t p;
    p.req.kind = kind;
    p.req.row = row;
    p.req.col = col;
    p.req.value = value;
    p.hold_for_drain = hold;
    pend.push_back(p);
  endtask

  // Reads, updates, deletes on the pool, plus fully random noise
  task automatic mixed_ops(int count);
    int n;
    int pick;
    int roll;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(POOL - 1);
      roll = $urandom_range(99);
      if (roll < 35)
        push_req(KIND_READ, pool_row[pick], pool_col[pick], $urandom, 1'b0);
      else if (roll < 65)
        push_req(KIND_WRITE, pool_row[pick], pool_col[pick], rand_nonzero(), 1'b0);
      else if (roll < 85)
        push_req(KIND_WRITE, pool_row[pick], pool_col[pick], '0, 1'b0);
      else
        push_req(1'($urandom_range(1)), 10'($urandom_range(1023)),
                 10'($urandom_range(1023)),
                 ($urandom_range(3) == 0) ? 32'sd0 : $signed(32'($urandom)), 1'b0);
    end
  endtask

  // One random phase: fill past capacity, churn, drain, churn
  task automatic run_phase();
    int i;
    int pick;
    for (i = 0; i < POOL; i++) begin
      pool_row[i] = 10'($urandom_range(1023));
      pool_col[i] = 10'($urandom_range(1023));
    end
    // first request waits for the block to go quiet
    for (i = 0; i < POOL; i++) begin
      push_req(KIND_WRITE, pool_row[i], pool_col[i], rand_nonzero(), i == 0);
      if ($urandom_range(5) == 0) begin
        pick = $urandom_range(POOL - 1);
        push_req(KIND_READ, pool_row[pick], pool_col[pick], $urandom, 1'b0);
      end
    end
    mixed_ops(MIXED_OPS);
    for (i = 0; i < DRAIN_OPS; i++) begin
      pick = $urandom_range(POOL - 1);
      if ($urandom_range(9) < 6)
        push_req(KIND_WRITE, pool_row[pick], pool_col[pick], '0, 1'b0);
      else
        push_req(KIND_READ, pool_row[pick], pool_col[pick], $urandom, 1'b0);
    end
    mixed_ops(MIXED_OPS);
  endtask

  // Request driver
  always @(posedge clk) begin : drive_requests
    bit took;
    bit send_next;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        expected_results.push_back(apply_to_table(in_data));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || took) begin
        send_next = (pend.size() > 0) && ($urandom_range(99) >= send_idle_pct);
        if (send_next && pend[0].hold_for_drain && (took || sent_count != got_count))
          send_next = 1'b0;
        if (send_next) begin
          in_data <= pend[0].req;
          pend.delete(0);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_count <= got_count + 1;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: read_value %0d", out_data.read_value);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_data.read_value);
            mismatches++;
          end
          if (out_data.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_data.found);
            mismatches++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, out_data.status);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int ph;
    for (ph = 0; ph < TABLE_SLOTS; ph++) slot_used[ph] = 1'b0;

    // Directed: extremes, update, deletes, absent keys
    push_req(KIND_READ,  10'd0,    10'd0,    '0,            1'b0);
    push_req(KIND_WRITE, 10'd0,    10'd0,    32'sh7fff_ffff, 1'b0);
    push_req(KIND_READ,  10'd0,    10'd0,    '0,            1'b0);
    push_req(KIND_WRITE, 10'd1023, 10'd1023, 32'sh8000_0000, 1'b0);
    push_req(KIND_READ,  10'd1023, 10'd1023, '0,            1'b0);
    push_req(KIND_WRITE, 10'd0,    10'd1023, -32'sd1,       1'b0);
    push_req(KIND_WRITE, 10'd1023, 10'd0,    32'sd1,        1'b0);
    push_req(KIND_READ,  10'd0,    10'd1023, '0,            1'b0);
    push_req(KIND_READ,  10'd1023, 10'd0,    '0,            1'b0);
    push_req(KIND_WRITE, 10'd0,    10'd0,    -32'sd5,       1'b0);
    push_req(KIND_READ,  10'd0,    10'd0,    -32'sd1,       1'b0);
    push_req(KIND_WRITE, 10'd5,    10'd5,    '0,            1'b0);
    push_req(KIND_READ,  10'd5,    10'd5,    '0,            1'b0);
    push_req(KIND_WRITE, 10'd1023, 10'd1023, '0,            1'b0);
    push_req(KIND_READ,  10'd1023, 10'd1023, '0,            1'b0);
    push_req(KIND_WRITE, 10'h2aa,  10'h155,  32'sh5555_5555, 1'b0);
    push_req(KIND_WRITE, 10'h155,  10'h2aa,  32'shaaaa_aaaa, 1'b0);
    push_req(KIND_READ,  10'h2aa,  10'h155,  '0,            1'b0);
    push_req(KIND_READ,  10'h155,  10'h2aa,  '0,            1'b0);
    push_req(KIND_WRITE, 10'd0,    10'd0,    '0,            1'b0);
    push_req(KIND_READ,  10'd0,    10'd0,    '0,            1'b0);
    push_req(KIND_WRITE, 10'd0,    10'd0,    32'sd123,      1'b0);
    push_req(KIND_READ,  10'd0,    10'd0,    '0,            1'b0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Three random phases with different idle patterns
    for (ph = 0; ph < 3; ph++) begin
      while (pend.size() != 0) @(posedge clk);
      @(negedge clk);
      case (ph)
        0: begin send_idle_pct = 14; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      run_phase();
    end

    // Let everything drain, then watch for stray results
    @(negedge clk);
    while (pend.size() != 0 || in_valid || sent_count != got_count) @(negedge clk);
    repeat (TABLE_SLOTS + 8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatches++;
    end

    $display("Ran %0d requests: %0d reads (%0d key hits overall), %0d writes, %0d deletes.",
             sent_count, n_reads, n_hits, n_writes, n_deletes);
    $display("%0d writes dropped on a full table; idle mixes 14/80, 80/14 and none.", n_full);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/scesu_pkg.sv
rtl/scesu_dpath.sv
rtl/scesu_ctrl.sv
rtl/sparse_coordinate_element_store_unit.sv
rtl/scesu_checker.sv
verif/tb.sv
